@@ rtl/omr_pkg.sv @@
// Shared types, constants and helpers for the optics matrix reconstruction block.
// No dependencies; the multiplier, top level, checker and bench import this package.
`timescale 1ns / 1ps
package omr_pkg;

  localparam int unsigned DW = 48;
  localparam int unsigned SUMW = 64;
  localparam logic signed [DW-1:0] Q_ONE = 48'sd4294967296;
  localparam logic signed [DW-1:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [DW-1:0] S48_MIN = 48'sh8000_0000_0000;
  localparam logic [46:0] CM_RESET = 47'd4294967296;
  localparam int unsigned NUM_VARS = 5;

  // transfer kinds
  localparam logic [1:0] KIND_DESC = 2'd0;
  localparam logic [1:0] KIND_COEF = 2'd1;
  localparam logic [1:0] KIND_EVAL = 2'd2;

  // target variable codes
  localparam logic [2:0] TV_DELTA = 3'd0;
  localparam logic [2:0] TV_THETA = 3'd1;
  localparam logic [2:0] TV_Y     = 3'd2;
  localparam logic [2:0] TV_YABS  = 3'd3;
  localparam logic [2:0] TV_PHI   = 3'd4;
  localparam logic [2:0] TV_PHABS = 3'd5;
  localparam logic [2:0] TV_PATH  = 3'd6;
  localparam logic [2:0] TV_NONE  = 3'd7;

  typedef enum logic [4:0] {
    ST_IDLE, ST_POW_INIT, ST_POW_MUL, ST_POW_WAIT,
    ST_EL_RD, ST_EL_DEC, ST_H_RD, ST_H_MUL, ST_H_WAIT,
    ST_C0_RD, ST_C0_ADD, ST_P_RD, ST_P_MUL, ST_P_WAIT,
    ST_ACC, ST_NEXT, ST_MOM, ST_MOM_WAIT, ST_DONE
  } state_e;

  typedef struct packed {
    logic                 start;
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
  } qmul_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [DW-1:0] p;
  } qmul_rsp_t;

  function automatic logic signed [DW-1:0] sat48(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] hi;
    logic signed [SUMW-1:0] lo;
    hi = SUMW'(S48_MAX);
    lo = SUMW'(S48_MIN);
    if (v > hi) return S48_MAX;
    if (v < lo) return S48_MIN;
    return v[DW-1:0];
  endfunction

  function automatic logic signed [SUMW-1:0] sx(input logic signed [DW-1:0] v);
    return {{(SUMW-DW){v[DW-1]}}, v};
  endfunction

endpackage

@@ rtl/omr_if.sv @@
// Valid/ready channel interfaces: track/load input, result output, config write.
// No dependencies; widths are written out as literals.
`timescale 1ns / 1ps
interface omr_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [7:0]          slot;
  logic [2:0]          target_var;
  logic [15:0]         exponents;
  logic [2:0]          coef_index;
  logic signed [47:0]  coef_value;
  logic signed [31:0]  x_fp;
  logic signed [31:0]  theta_fp;
  logic signed [31:0]  y_fp;
  logic signed [31:0]  phi_fp;
  modport source (output valid, kind, slot, target_var, exponents, coef_index, coef_value,
                  x_fp, theta_fp, y_fp, phi_fp, input ready);
  modport sink (input valid, kind, slot, target_var, exponents, coef_index, coef_value,
                x_fp, theta_fp, y_fp, phi_fp, output ready);
endinterface

interface omr_out_if;
  logic                valid;
  logic                ready;
  logic signed [47:0]  target_theta;
  logic signed [47:0]  target_phi;
  logic signed [47:0]  target_y;
  logic signed [47:0]  delta_p;
  logic signed [47:0]  momentum;
  logic signed [47:0]  path_length;
  modport source (output valid, target_theta, target_phi, target_y, delta_p, momentum,
                  path_length, input ready);
  modport sink (input valid, target_theta, target_phi, target_y, delta_p, momentum,
                path_length, output ready);
endinterface

interface omr_cfg_if;
  logic        valid;
  logic        ready;
  logic [46:0] central_momentum;
  modport source (output valid, central_momentum, input ready);
  modport sink (input valid, central_momentum, output ready);
endinterface

@@ rtl/omr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module omr_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/omr_qmul.sv @@
// Shared Q16.32 multiplier: 48x16 partial product per cycle, round, saturate.
// Depends on omr_pkg (request/response structs, limits).
`timescale 1ns / 1ps
module omr_qmul (
  input  logic clk_i,
  input  logic rst_ni,
  input  omr_pkg::qmul_req_t req_i,
  output omr_pkg::qmul_rsp_t rsp_o
);
  import omr_pkg::*;

  localparam logic [1:0] LAST_DIGIT = 2'd2;

  logic            busy_q, fin_q, done_q;
  logic [1:0]      cnt_q;
  logic            neg_q;
  logic [DW-1:0]   ua_q, ub_q;
  logic [95:0]     acc_q;
  logic signed [DW-1:0] res_q;

  logic [95:0]     rnd;
  logic [63:0]     mag;
  logic signed [DW-1:0] res_d;
  logic [63:0]     pp;

  // both operands widened to 64 bits so the 48x16 product keeps every bit
  assign pp  = {16'h0, ua_q} * {48'h0, ub_q[DW-1:DW-16]};
  assign rnd = acc_q + 96'h8000_0000;
  assign mag = rnd[95:32];

  always_comb begin
    if (neg_q) begin
      if (mag >= 64'h8000_0000_0000) res_d = S48_MIN;
      else res_d = -$signed(mag[DW-1:0]);
    end else begin
      if (mag > 64'(S48_MAX)) res_d = S48_MAX;
      else res_d = $signed(mag[DW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == LAST_DIGIT) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.a[DW-1] ^ req_i.b[DW-1];
      ua_q  <= req_i.a[DW-1] ? -req_i.a : req_i.a;
      ub_q  <= req_i.b[DW-1] ? -req_i.b : req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= {acc_q[79:0], 16'h0} + 96'(pp);
      ub_q  <= {ub_q[DW-17:0], 16'h0};
    end
    if (fin_q) begin
      res_q <= res_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = res_q;
endmodule

@@ rtl/optics_matrix_reconstruction.sv @@
// Top level: element tables, power table, sequencer and result register.
// Depends on omr_pkg, omr_if interfaces, omr_ram and omr_qmul.
//
// Usage:
//   in_i  carries load and evaluate transfers. Descriptor and coefficient loads
//         write their table on the transfer; in_i.ready stays high, so loads go back to back.
//   An evaluate transfer drops in_i.ready until its result is registered. The
//   block first builds a table of powers 0..MAX_POWER-1 of x, theta, y, phi and
//   |theta|. Then it walks every element slot: an unused slot gets no products,
//   a used one takes POLY_ORDER-1 Horner products plus 3 or 4 power products.
//   Every product goes through the one shared multiplier (start, three 48x16
//   digits, round/saturate, handoff), with RAM reads in between. The momentum
//   product and the result load come last; one evaluate is in flight at a time.
//   out_o holds the result in a register: a stalled receiver keeps it there,
//   and loads still go in meanwhile. A finished evaluate waits for the register.
//   cfg_i writes central_momentum at any cycle (ready is always high); write it
//   only while idle.
//   Reset: asynchronous, active low. All descriptors read as unused (per-slot
//   valid bits clear at once, no clearing pass); central momentum is 1.0.
//   Coefficients are not reset and must be loaded before an element is used.
`timescale 1ns / 1ps
module optics_matrix_reconstruction #(
  parameter int unsigned MAX_ELEMENTS = 256,
  parameter int unsigned POLY_ORDER   = 7,
  parameter int unsigned MAX_POWER    = 10
) (
  input  logic clk_i,
  input  logic rst_ni,
  omr_in_if.sink    in_i,
  omr_out_if.source out_o,
  omr_cfg_if.sink   cfg_i
);
  import omr_pkg::*;

  localparam int unsigned AW  = MAX_ELEMENTS > 1 ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CD  = MAX_ELEMENTS * POLY_ORDER;
  localparam int unsigned CAW = CD > 1 ? $clog2(CD) : 1;
  localparam int unsigned IW  = POLY_ORDER > 1 ? $clog2(POLY_ORDER) : 1;
  localparam int unsigned PD  = 128;   // {var[2:0], power[3:0]}
  localparam logic [3:0] P_LAST = 4'(MAX_POWER - 1);
  localparam logic [AW-1:0] E_LAST = AW'(MAX_ELEMENTS - 1);
  localparam logic [IW-1:0] I_TOP = IW'(POLY_ORDER - 1);

  state_e state_q, state_d;

  logic [AW-1:0]        e_q, e_d;
  logic [IW-1:0]        i_q, i_d;
  logic [2:0]           k_q, k_d;
  logic [3:0]           p_q, p_d;
  logic signed [DW-1:0] v_q, v_d;
  logic [2:0]           tv_q, tv_d;
  logic [15:0]          exp_q, exp_d;
  logic signed [DW-1:0] base_q [NUM_VARS];
  logic signed [SUMW-1:0] sum_q [7];
  logic [46:0]          cm_q;
  logic [MAX_ELEMENTS-1:0] dvalid_q;
  logic                 ovalid_q;

  // control decoded in the output block
  logic                 load_base, clear_sums, add_sum, load_out;
  qmul_req_t            mreq;
  qmul_rsp_t            mrsp;

  // memories
  logic                 d_we, c_we, p_we;
  logic [AW-1:0]        d_waddr, d_raddr;
  logic [18:0]          d_wdata, d_rdata;
  logic [CAW-1:0]       c_waddr, c_raddr;
  logic [DW-1:0]        c_rdata;
  logic [6:0]           p_waddr, p_raddr;
  logic signed [DW-1:0] p_wdata;
  logic [DW-1:0]        p_rdata;

  logic                 in_xfer;
  logic [31:0]          slot_w;
  logic                 slot_ok, exp_ok;
  logic [2:0]           np_last;
  logic [2:0]           pvar;
  logic [3:0]           nib;
  logic signed [DW-1:0] xh;
  logic signed [DW-1:0] dp, onep;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_xfer     = in_i.valid & in_i.ready;
  assign slot_w      = 32'(in_i.slot);
  assign slot_ok     = slot_w < MAX_ELEMENTS;

  always_comb begin
    exp_ok = 1'b1;
    for (int n = 0; n < 4; n++) begin
      if (32'(in_i.exponents[4*n +: 4]) >= MAX_POWER) exp_ok = 1'b0;
    end
  end

  // load writes
  assign d_we    = in_xfer && in_i.kind == KIND_DESC && slot_ok && exp_ok;
  assign d_waddr = AW'(slot_w);
  assign d_wdata = {in_i.target_var, in_i.exponents};
  assign c_we    = in_xfer && in_i.kind == KIND_COEF && slot_ok &&
                   32'(in_i.coef_index) < POLY_ORDER;
  assign c_waddr = CAW'(slot_w * POLY_ORDER + 32'(in_i.coef_index));

  // element decode helpers
  assign np_last = (tv_q == TV_YABS || tv_q == TV_PHABS || tv_q == TV_PATH) ? 3'd3 : 3'd2;
  assign pvar    = (tv_q == TV_PATH) ? k_q : k_q + 3'd1;
  assign nib     = exp_q[4*k_q[1:0] +: 4];
  assign xh      = (tv_q == TV_PATH) ? Q_ONE : base_q[0];
  assign dp      = sat48(sum_q[TV_DELTA]);
  assign onep    = sat48(sx(Q_ONE) + sx(dp));

  assign d_raddr = e_q;
  assign p_raddr = {pvar, nib};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_xfer && in_i.kind == KIND_EVAL) state_d = ST_POW_INIT;
      ST_POW_INIT: state_d = ST_POW_MUL;
      ST_POW_MUL:  state_d = ST_POW_WAIT;
      ST_POW_WAIT: begin
        if (mrsp.done) begin
          if (p_q != P_LAST) state_d = ST_POW_MUL;
          else if (k_q == 3'(NUM_VARS - 1)) state_d = ST_EL_RD;
          else state_d = ST_POW_INIT;
        end
      end
      ST_EL_RD:    state_d = ST_EL_DEC;
      ST_EL_DEC: begin
        if (!dvalid_q[e_q] || d_rdata[18:16] == TV_NONE) state_d = ST_NEXT;
        else if (POLY_ORDER > 1) state_d = ST_H_RD;
        else state_d = ST_C0_RD;
      end
      ST_H_RD:     state_d = ST_H_MUL;
      ST_H_MUL:    state_d = ST_H_WAIT;
      ST_H_WAIT: begin
        if (mrsp.done) state_d = (i_q == IW'(1)) ? ST_C0_RD : ST_H_RD;
      end
      ST_C0_RD:    state_d = ST_C0_ADD;
      ST_C0_ADD:   state_d = ST_P_RD;
      ST_P_RD:     state_d = ST_P_MUL;
      ST_P_MUL:    state_d = ST_P_WAIT;
      ST_P_WAIT: begin
        if (mrsp.done) state_d = (k_q == np_last) ? ST_ACC : ST_P_RD;
      end
      ST_ACC:      state_d = ST_NEXT;
      ST_NEXT:     state_d = (e_q == E_LAST) ? ST_MOM : ST_EL_RD;
      ST_MOM:      state_d = ST_MOM_WAIT;
      ST_MOM_WAIT: if (mrsp.done) state_d = ST_DONE;
      ST_DONE:     if (!ovalid_q) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    e_d = e_q; i_d = i_q; k_d = k_q; p_d = p_q; v_d = v_q;
    tv_d = tv_q; exp_d = exp_q;
    load_base = 1'b0; clear_sums = 1'b0; add_sum = 1'b0; load_out = 1'b0;
    mreq    = '{start: 1'b0, a: v_q, b: base_q[k_q]};
    p_we    = 1'b0;
    p_waddr = {k_q, p_q};
    p_wdata = mrsp.p;
    c_raddr = CAW'(32'(e_q) * POLY_ORDER + 32'(i_q));
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && in_i.kind == KIND_EVAL) begin
          load_base  = 1'b1;
          clear_sums = 1'b1;
          k_d        = 3'd0;
        end
      end
      ST_POW_INIT: begin
        p_we    = 1'b1;
        p_waddr = {k_q, 4'd0};
        p_wdata = Q_ONE;
        v_d     = Q_ONE;
        p_d     = 4'd1;
      end
      ST_POW_MUL: begin
        mreq.start = 1'b1;
      end
      ST_POW_WAIT: begin
        if (mrsp.done) begin
          p_we = 1'b1;
          v_d  = mrsp.p;
          if (p_q != P_LAST) p_d = p_q + 4'd1;
          else if (k_q == 3'(NUM_VARS - 1)) e_d = '0;
          else k_d = k_q + 3'd1;
        end
      end
      ST_EL_DEC: begin
        tv_d  = d_rdata[18:16];
        exp_d = d_rdata[15:0];
        v_d   = '0;
        i_d   = I_TOP;
      end
      ST_H_MUL: begin
        mreq.start = 1'b1;
        mreq.a     = xh;
        mreq.b     = sat48(sx(v_q) + sx($signed(c_rdata)));
      end
      ST_H_WAIT: begin
        if (mrsp.done) begin
          v_d = mrsp.p;
          i_d = i_q - IW'(1);
        end
      end
      ST_C0_RD: begin
        c_raddr = CAW'(32'(e_q) * POLY_ORDER);
      end
      ST_C0_ADD: begin
        v_d = sat48(sx(v_q) + sx($signed(c_rdata)));
        k_d = 3'd0;
      end
      ST_P_MUL: begin
        mreq.start = 1'b1;
        mreq.b     = $signed(p_rdata);
      end
      ST_P_WAIT: begin
        if (mrsp.done) begin
          v_d = mrsp.p;
          k_d = k_q + 3'd1;
        end
      end
      ST_ACC: add_sum = 1'b1;
      ST_NEXT: begin
        if (e_q != E_LAST) e_d = e_q + AW'(1);
      end
      ST_MOM: begin
        mreq.start = 1'b1;
        mreq.a     = {1'b0, cm_q};
        mreq.b     = onep;
      end
      ST_MOM_WAIT: if (mrsp.done) v_d = mrsp.p;
      ST_DONE: load_out = !ovalid_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      dvalid_q <= '0;
      ovalid_q <= 1'b0;
      cm_q     <= CM_RESET;
    end else begin
      state_q <= state_d;
      if (d_we) dvalid_q[d_waddr] <= 1'b1;
      if (cfg_i.valid) cm_q <= cfg_i.central_momentum;
      if (load_out) ovalid_q <= 1'b1;
      else if (out_o.ready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q <= e_d; i_q <= i_d; k_q <= k_d; p_q <= p_d; v_q <= v_d;
    tv_q <= tv_d; exp_q <= exp_d;
    if (load_base) begin
      base_q[0] <= {{8{in_i.x_fp[31]}}, in_i.x_fp, 8'h00};
      base_q[1] <= {{8{in_i.theta_fp[31]}}, in_i.theta_fp, 8'h00};
      base_q[2] <= {{8{in_i.y_fp[31]}}, in_i.y_fp, 8'h00};
      base_q[3] <= {{8{in_i.phi_fp[31]}}, in_i.phi_fp, 8'h00};
      base_q[4] <= in_i.theta_fp[31] ? -{{8{in_i.theta_fp[31]}}, in_i.theta_fp, 8'h00}
                                     :  {{8{in_i.theta_fp[31]}}, in_i.theta_fp, 8'h00};
    end
    if (clear_sums) begin
      for (int s = 0; s < 7; s++) sum_q[s] <= '0;
    end else if (add_sum) begin
      sum_q[tv_q] <= sum_q[tv_q] + sx(v_q);
    end
    if (load_out) begin
      out_o.target_theta <= sat48(sum_q[TV_THETA]);
      out_o.target_phi   <= sat48(sum_q[TV_PHI] + sum_q[TV_PHABS]);
      out_o.target_y     <= sat48(sum_q[TV_Y] + sum_q[TV_YABS]);
      out_o.delta_p      <= dp;
      out_o.momentum     <= v_q;
      out_o.path_length  <= sat48(sum_q[TV_PATH]);
    end
  end

  assign out_o.valid = ovalid_q;

  omr_ram #(.WIDTH(19), .DEPTH(MAX_ELEMENTS)) u_desc_ram (
    .clk_i, .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .raddr_i(d_raddr), .rdata_o(d_rdata)
  );

  omr_ram #(.WIDTH(DW), .DEPTH(CD)) u_coef_ram (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(in_i.coef_value),
    .raddr_i(c_raddr), .rdata_o(c_rdata)
  );

  omr_ram #(.WIDTH(DW), .DEPTH(PD)) u_pow_ram (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  omr_qmul u_qmul (.clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp));
endmodule

@@ rtl/omr_checker.sv @@
// Port-level checker for the reconstruction block, bound to the top level.
// Depends on omr_pkg for the kind codes.
`timescale 1ns / 1ps
module omr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_kind,
  input logic       out_valid,
  input logic       out_ready,
  input logic       cfg_ready
);
  import omr_pkg::*;

  // an evaluate holds off further input
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_kind == KIND_EVAL |=> !in_ready)
    else $error("input ready right after an evaluate transfer");

  // loads never stall the input
  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_kind != KIND_EVAL |=> in_ready)
    else $error("input stalled after a load transfer");

  // result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_cfg_open: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready)
    else $error("config channel not ready");
endmodule

bind optics_matrix_reconstruction omr_checker u_omr_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_i.valid), .in_ready(in_i.ready), .in_kind(in_i.kind),
  .out_valid(out_o.valid), .out_ready(out_o.ready), .cfg_ready(cfg_i.ready)
);

@@ bench/tb_optics_matrix_reconstruction.sv @@
// Self-checking bench for optics_matrix_reconstruction: loads, evaluates, config writes.
// Depends on omr_pkg and the omr_if channel interfaces; drives valid/ready with random gaps.
`timescale 1ns / 1ps
module tb_optics_matrix_reconstruction;
  import omr_pkg::*;

  localparam int NSLOT = 256;
  localparam int NCOEF = 7;
  localparam int NPOW  = 10;
  localparam longint ONE_Q = 64'sd4294967296;
  localparam longint MAX48 = 64'sd140737488355327;
  localparam longint MIN48 = -64'sd140737488355328;

  typedef struct {
    logic [1:0]         kind;
    logic [7:0]         slot;
    logic [2:0]         target_var;
    logic [15:0]        exponents;
    logic [2:0]         coef_index;
    logic signed [47:0] coef_value;
    logic signed [31:0] x_fp, theta_fp, y_fp, phi_fp;
  } track_item_t;

  typedef struct {
    logic signed [47:0] theta, phi, y, delta, mom, path;
  } recon_t;

  typedef struct {
    track_item_t item;
    bit          typed;   // expected result given in the row
    recon_t      want;
  } stim_row_t;

  logic clk_i, rst_ni;
  omr_in_if  in_bus();
  omr_out_if out_bus();
  omr_cfg_if cfg_bus();

  optics_matrix_reconstruction dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_bus), .out_o(out_bus), .cfg_i(cfg_bus)
  );

  // shadow of the block state
  logic [2:0]  desc_tv[NSLOT];
  logic [15:0] desc_ex[NSLOT];
  longint      coef_mem[NSLOT][NCOEF];
  bit          coef_set[NSLOT][NCOEF];
  longint      cm_shadow;

  recon_t recon_q[$];
  int     err_count, eval_count, load_count;
  bit     calm;        // no idling on either side
  bit     hold_req;    // ask the receiver for a long hold-off

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #30ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------- arithmetic of the block ----------------
  function automatic longint clamp48(longint v);
    if (v > MAX48) return MAX48;
    if (v < MIN48) return MIN48;
    return v;
  endfunction

  // Q16.32 product, round half away from zero, saturate
  function automatic longint qprod(longint a, longint b);
    bit neg;
    bit [63:0] ua, ub, mag;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 64'd0 - a : a;
    ub = (b < 0) ? 64'd0 - b : b;
    mag = (((ua >> 32) * (ub >> 32)) << 32) + (ua >> 32) * ub[31:0]
        + ua[31:0] * (ub >> 32) + ((ua[31:0] * ub[31:0] + 64'h8000_0000) >> 32);
    if (neg) return (mag >= 64'h8000_0000_0000) ? MIN48 : -longint'(mag);
    return (mag > 64'(MAX48)) ? MAX48 : longint'(mag);
  endfunction

  function automatic longint horner_eval(longint x, int e);
    longint v;
    v = 0;
    for (int i = NCOEF - 1; i >= 1; i--) v = qprod(x, clamp48(v + coef_mem[e][i]));
    return clamp48(v + coef_mem[e][0]);
  endfunction

  function automatic recon_t reconstruct_track(track_item_t it);
    longint base[5], pw[NPOW][5], sum[7], v, dp;
    int np;
    recon_t r;
    base[0] = longint'(it.x_fp) * 256;
    base[1] = longint'(it.theta_fp) * 256;
    base[2] = longint'(it.y_fp) * 256;
    base[3] = longint'(it.phi_fp) * 256;
    base[4] = base[1] < 0 ? -base[1] : base[1];
    for (int k = 0; k < 5; k++) begin
      pw[0][k] = ONE_Q;
      for (int i = 1; i < NPOW; i++) pw[i][k] = qprod(pw[i-1][k], base[k]);
    end
    for (int k = 0; k < 7; k++) sum[k] = 0;
    for (int e = 0; e < NSLOT; e++) begin
      if (desc_tv[e] == TV_NONE) continue;
      if (desc_tv[e] == TV_PATH) begin
        // path length: coefficients summed, powers of x, theta, y, phi
        v = horner_eval(ONE_Q, e);
        for (int k = 0; k < 4; k++) v = qprod(v, pw[desc_ex[e][4*k +: 4]][k]);
      end else begin
        np = (desc_tv[e] == TV_YABS || desc_tv[e] == TV_PHABS) ? 4 : 3;
        v = horner_eval(base[0], e);
        for (int k = 0; k < np; k++) v = qprod(v, pw[desc_ex[e][4*k +: 4]][k+1]);
      end
      sum[desc_tv[e]] += v;
    end
    dp = clamp48(sum[0]);
    r.theta = 48'(clamp48(sum[1]));
    r.phi   = 48'(clamp48(sum[4] + sum[5]));
    r.y     = 48'(clamp48(sum[2] + sum[3]));
    r.delta = 48'(dp);
    r.mom   = 48'(qprod(cm_shadow, clamp48(ONE_Q + dp)));
    r.path  = 48'(clamp48(sum[6]));
    return r;
  endfunction

  // state update of load transfers; evaluates return a result
  task automatic apply_item(track_item_t it, bit typed, recon_t want);
    bit ok;
    case (it.kind)
      KIND_DESC: begin
        ok = 1'b1;
        for (int k = 0; k < 4; k++) if (it.exponents[4*k +: 4] >= NPOW) ok = 1'b0;
        if (ok) begin
          desc_tv[it.slot] = it.target_var;
          desc_ex[it.slot] = it.exponents;
        end
        load_count++;
      end
      KIND_COEF: begin
        if (it.coef_index < NCOEF) begin
          coef_mem[it.slot][it.coef_index] = it.coef_value;
          coef_set[it.slot][it.coef_index] = 1'b1;
        end
        load_count++;
      end
      KIND_EVAL: begin
        recon_q.insert(recon_q.size(), typed ? want : reconstruct_track(it));
        eval_count++;
      end
      default: ;  // kind three is dropped
    endcase
  endtask

  // ---------------- drivers ----------------
  task automatic send_item(track_item_t it, bit typed = 1'b0, recon_t want = '{default: 0});
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_bus.kind = it.kind;           in_bus.slot = it.slot;
    in_bus.target_var = it.target_var; in_bus.exponents = it.exponents;
    in_bus.coef_index = it.coef_index; in_bus.coef_value = it.coef_value;
    in_bus.x_fp = it.x_fp;           in_bus.theta_fp = it.theta_fp;
    in_bus.y_fp = it.y_fp;           in_bus.phi_fp = it.phi_fp;
    in_bus.valid = 1'b1;
    do @(posedge clk_i); while (!in_bus.ready);
    apply_item(it, typed, want);
    @(negedge clk_i);
    in_bus.valid = 1'b0;
  endtask

  task automatic write_momentum(logic [46:0] val);
    cfg_bus.central_momentum = val;
    cfg_bus.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cm_shadow = longint'(val);
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (recon_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_bus.ready = 1'b0;
        repeat (6000) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_bus.ready = calm || ($urandom_range(0, 99) >= 20);
    end
  end

  // ---------------- checking ----------------
  task automatic report_mismatch(string what, logic signed [47:0] got, logic signed [47:0] want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    recon_t w;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (recon_q.size() == 0) begin
        report_mismatch("unexpected result transfer", out_bus.momentum, 48'sd0);
      end else begin
        w = recon_q.pop_front();
        if (out_bus.target_theta !== w.theta) report_mismatch("target_theta", out_bus.target_theta, w.theta);
        if (out_bus.target_phi !== w.phi)     report_mismatch("target_phi", out_bus.target_phi, w.phi);
        if (out_bus.target_y !== w.y)         report_mismatch("target_y", out_bus.target_y, w.y);
        if (out_bus.delta_p !== w.delta)      report_mismatch("delta_p", out_bus.delta_p, w.delta);
        if (out_bus.momentum !== w.mom)       report_mismatch("momentum", out_bus.momentum, w.mom);
        if (out_bus.path_length !== w.path)   report_mismatch("path_length", out_bus.path_length, w.path);
      end
    end
  end

  // ---------------- random content ----------------
  function automatic logic signed [31:0] rand_track();
    if ($urandom_range(0, 99) < 80) return $signed($urandom_range(0, 33554432)) - 32'sd16777216;
    return $urandom;
  endfunction

  function automatic logic signed [47:0] rand_coef();
    logic signed [63:0] r;
    r = {$urandom, $urandom};
    return ($urandom_range(0, 99) < 75) ? 48'(r >>> 28) : 48'(r >>> 16);
  endfunction

  function automatic logic [15:0] rand_exps();
    logic [15:0] e;
    for (int k = 0; k < 4; k++)
      e[4*k +: 4] = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 2)) : 4'($urandom_range(0, 9));
    if ($urandom_range(0, 99) < 10) e[4*$urandom_range(0, 3) +: 4] = 4'($urandom_range(10, 15));
    return e;
  endfunction

  function automatic bit slot_loaded(int s);
    for (int i = 0; i < NCOEF; i++) if (!coef_set[s][i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic track_item_t rand_item();
    track_item_t it;
    int pick;
    bit ok;
    it.kind = KIND_EVAL;
    it.slot = 8'($urandom); it.target_var = 3'($urandom); it.exponents = 16'($urandom);
    it.coef_index = 3'($urandom); it.coef_value = rand_coef();
    it.x_fp = rand_track(); it.theta_fp = rand_track();
    it.y_fp = rand_track(); it.phi_fp = rand_track();
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it.kind = KIND_COEF;
      if ($urandom_range(0, 9) != 0) it.slot = 8'($urandom_range(0, 15));
    end else if (pick < 55) begin
      it.kind = KIND_DESC;
      it.slot = 8'($urandom_range(0, 15));
      it.exponents = rand_exps();
      ok = 1'b1;
      for (int k = 0; k < 4; k++) if (it.exponents[4*k +: 4] >= NPOW) ok = 1'b0;
      // never let an element go live before all its coefficients are in
      if (ok && !slot_loaded(it.slot)) it.target_var = TV_NONE;
    end else if (pick < 62) begin
      it.kind = 2'd3;
    end
    return it;
  endfunction

  // ---------------- stimulus ----------------
  stim_row_t dir_rows[$];

  function automatic void add_row(stim_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic track_item_t mk(logic [1:0] kind, logic [7:0] slot, logic [2:0] tv,
                                     logic [15:0] ex, logic [2:0] ci, logic signed [47:0] cv);
    track_item_t it;
    it = '{kind: kind, slot: slot, target_var: tv, exponents: ex, coef_index: ci,
           coef_value: cv, x_fp: 32'sd16777216, theta_fp: 32'sd8388608,
           y_fp: -32'sd4194304, phi_fp: 32'sd2097152};
    return it;
  endfunction

  initial begin
    track_item_t it;
    recon_t empty_tab, zero_cm;
    stim_row_t row;
    logic [46:0] cm_set[4];

    in_bus.valid = 1'b0; in_bus.kind = KIND_DESC; in_bus.slot = '0; in_bus.target_var = '0;
    in_bus.exponents = '0; in_bus.coef_index = '0; in_bus.coef_value = '0;
    in_bus.x_fp = '0; in_bus.theta_fp = '0; in_bus.y_fp = '0; in_bus.phi_fp = '0;
    cfg_bus.valid = 1'b0; cfg_bus.central_momentum = '0;
    calm = 1'b0; hold_req = 1'b0; err_count = 0; eval_count = 0; load_count = 0;
    cm_shadow = ONE_Q;
    for (int s = 0; s < NSLOT; s++) begin
      desc_tv[s] = TV_NONE; desc_ex[s] = '0;
      for (int i = 0; i < NCOEF; i++) begin
        coef_mem[s][i] = 0; coef_set[s][i] = 1'b0;
      end
    end
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table: every sum zero, momentum is the central value
    empty_tab = '{theta: 0, phi: 0, y: 0, delta: 0, mom: 48'(ONE_Q), path: 0};
    zero_cm   = '{default: 0};

    row = '{item: mk(KIND_EVAL, 0, 0, 0, 0, 0), typed: 1, want: empty_tab};
    row.item.x_fp = 0; row.item.theta_fp = 0; row.item.y_fp = 0; row.item.phi_fp = 0;
    add_row(row);
    row.item.x_fp = 32'h7FFF_FFFF; row.item.theta_fp = 32'h8000_0000;
    row.item.y_fp = 32'h7FFF_FFFF; row.item.phi_fp = 32'h8000_0000;
    add_row(row);
    // coefficients of slot 0, both extremes among them
    add_row('{item: mk(KIND_COEF, 0, 0, 0, 0, 48'(MAX48)), typed: 0, want: zero_cm});
    for (int i = 1; i < 6; i++)
      add_row('{item: mk(KIND_COEF, 0, 0, 0, 3'(i), 48'sd1 <<< (28 + i)),
                typed: 0, want: zero_cm});
    add_row('{item: mk(KIND_COEF, 0, 0, 0, 6, 48'(MIN48)), typed: 0, want: zero_cm});
    // index past the polynomial order is dropped
    add_row('{item: mk(KIND_COEF, 0, 0, 0, 7, 48'sd12345), typed: 0, want: zero_cm});
    // nibble of ten rejects the whole descriptor; still empty table
    add_row('{item: mk(KIND_DESC, 0, TV_THETA, 16'h00A1, 0, 0), typed: 0, want: zero_cm});
    add_row('{item: mk(2'd3, 0, 0, 0, 0, 0), typed: 0, want: zero_cm});
    add_row('{item: mk(KIND_EVAL, 0, 0, 0, 0, 0), typed: 1, want: empty_tab});
    add_row('{item: mk(KIND_DESC, 0, TV_THETA, 16'h0321, 0, 0), typed: 0, want: zero_cm});
    add_row('{item: mk(KIND_EVAL, 0, 0, 0, 0, 0), typed: 0, want: zero_cm});
    row = '{item: mk(KIND_EVAL, 0, 0, 0, 0, 0), typed: 0, want: zero_cm};
    row.item.x_fp = 32'h7FFF_FFFF; row.item.theta_fp = 32'h8000_0000;
    add_row(row);
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    // load coefficients for slots 1 to 11, which the random part can bring to life
    for (int s = 1; s < 12; s++)
      for (int i = 0; i < NCOEF; i++)
        send_item(mk(KIND_COEF, 8'(s), 0, 0, 3'(i), rand_coef()));

    cm_set[0] = 47'd0;
    cm_set[1] = 47'h7FFF_FFFF_FFFF;
    cm_set[2] = 47'd4294967296;
    cm_set[3] = 47'({$urandom, $urandom});
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      write_momentum(cm_set[ph]);
      calm = (ph == 2);
      if (ph == 1) hold_req = 1'b1;
      for (int n = 0; n < 30; n++) begin
        it = rand_item();
        send_item(it);
      end
    end
    calm = 1'b0;
    wait_drained();
    repeat (200) @(negedge clk_i);

    $display("covered %0d evaluates and %0d table loads over four momentum settings",
             eval_count, load_count);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", err_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/omr_pkg.sv
rtl/omr_if.sv
rtl/omr_ram.sv
rtl/omr_qmul.sv
rtl/optics_matrix_reconstruction.sv
rtl/omr_checker.sv
bench/tb_optics_matrix_reconstruction.sv
